// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// boolean condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/ppmmu_pkg.sv -----
// types and constants of the per-process mmu
`default_nettype none

package ppmmu_pkg;

  localparam int FUNC_W   = 2;
  localparam int PROC_W   = 2;
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 13;
  localparam int PAGE_W   = 4;
  localparam int FRAME_W  = 6;
  localparam int RIGHTS_W = 3;
  localparam int PA_W     = 15;
  localparam int STATUS_W = 2;

  localparam int DATA_BASE_BYTES = 1024;

  localparam logic [RIGHTS_W-1:0] RIGHT_READ  = 3'b001;
  localparam logic [RIGHTS_W-1:0] RIGHT_WRITE = 3'b010;
  localparam logic [RIGHTS_W-1:0] RIGHT_EXEC  = 3'b100;

  typedef enum logic [FUNC_W-1:0] {
    FN_TRANSLATE = 2'd0,
    FN_WRITE     = 2'd1,
    FN_FLUSH     = 2'd2,
    FN_CLEAR     = 2'd3
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    ACC_READ  = 2'd0,
    ACC_WRITE = 2'd1,
    ACC_EXEC  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_PAGE_FAULT = 2'd1,
    ST_PROT_FAULT = 2'd2,
    ST_IGNORED    = 2'd3
  } status_e;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic [RIGHTS_W-1:0] rights;
  } pt_entry_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   page;
    logic [FRAME_W-1:0]  frame;
    logic [RIGHTS_W-1:0] rights;
  } tlb_entry_t;

  typedef struct packed {
    logic rd_en;
    logic fill_en;
    logic flush_en;
  } tlb_cmd_t;

  typedef struct packed {
    logic                hit;
    logic [FRAME_W-1:0]  frame;
    logic [RIGHTS_W-1:0] rights;
  } tlb_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/ppmmu_tlb.sv -----
// per-process fifo tlb: one memory row per process, fill pointers and lookup
`default_nettype none

module ppmmu_tlb #(
  parameter int PROCESSES = 4,
  parameter int TLB_DEPTH = 4,
  parameter int PRW       = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ppmmu_pkg::tlb_cmd_t          cmd_i,
  input  wire logic [PRW-1:0]               rd_proc_i,
  input  wire logic [PRW-1:0]               proc_i,
  input  wire logic [ppmmu_pkg::PAGE_W-1:0] page_i,
  input  wire logic                         page_ok_i,
  input  wire ppmmu_pkg::tlb_entry_t        fill_i,
  output ppmmu_pkg::tlb_res_t               res_o
);
  import ppmmu_pkg::*;

  localparam int SLW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;

  typedef tlb_entry_t [TLB_DEPTH-1:0] row_t;

  row_t           tlb_mem [PROCESSES];
  row_t           rd_row_q;
  row_t           wr_row;
  logic [SLW-1:0] fill_ptr_q [PROCESSES];
  logic           full_q [PROCESSES];
  logic [SLW-1:0] slot;
  logic [SLW-1:0] slot_next;
  logic           wrap;
  logic [TLB_DEPTH-1:0] match;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_row_q <= tlb_mem[rd_proc_i];
    end
    if (cmd_i.fill_en) begin
      tlb_mem[proc_i] <= wr_row;
    end
  end

  assign slot      = fill_ptr_q[proc_i];
  assign wrap      = (slot == SLW'(TLB_DEPTH - 1));
  assign slot_next = wrap ? '0 : slot + 1'b1;

  always_comb begin
    wr_row       = rd_row_q;
    wr_row[slot] = fill_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PROCESSES; i++) begin
        fill_ptr_q[i] <= '0;
        full_q[i]     <= 1'b0;
      end
    end else if (cmd_i.flush_en) begin
      fill_ptr_q[proc_i] <= '0;
      full_q[proc_i]     <= 1'b0;
    end else if (cmd_i.fill_en) begin
      fill_ptr_q[proc_i] <= slot_next;
      if (wrap) begin
        full_q[proc_i] <= 1'b1;
      end
    end
  end

  // slots below the fill pointer are valid until the first wrap
  always_comb begin
    for (int i = 0; i < TLB_DEPTH; i++) begin
      match[i] = (full_q[proc_i] || (SLW'(i) < slot)) && (rd_row_q[i].page == page_i);
    end
  end

  always_comb begin
    res_o = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (match[i] && page_ok_i) begin
        res_o.hit    = 1'b1;
        res_o.frame  = rd_row_q[i].frame;
        res_o.rights = rd_row_q[i].rights;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/per_process_tlb_mmu_top.sv -----
// top level of the per-process mmu: request stage, page table and result register
//
// usage:
// - one request channel (in_valid_i / in_stall_o) carries func, process, access kind,
//   address, page, frame and rights; one result channel (out_valid_o / out_stall_i)
//   returns physical address, status and tlb hit flag, exactly one item per request
// - an accepted item reads the process's tlb row and its page-table entry from two
//   synchronous memories; the execute stage then checks rights, fills the tlb on a miss,
//   writes or clears the page table or flushes the tlb, and loads the result register
// - the input stalls after each accept until the item leaves the execute stage, so the
//   block takes no new item while one is in flight; the page-table and tlb memories
//   are read synchronously
// - a finished result waits in the output register while out_stall_i is high; one
//   more item may be accepted and then holds in the execute stage until the result
//   register frees up
// - reset clears all page-table valid bits, all tlb fill pointers and the control
//   state at once; no clearing pass follows, items are taken right after reset
// - page size must be a power of two
`default_nettype none
`include "assert_macros.svh"

module per_process_tlb_mmu_top #(
  parameter int PROCESSES     = 4,
  parameter int TLB_DEPTH     = 4,
  parameter int LOGICAL_PAGES = 10,
  parameter int PAGE_BYTES    = 512,
  parameter int FRAMES        = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [ppmmu_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [ppmmu_pkg::PROC_W-1:0]   process_i,
  input  wire logic [ppmmu_pkg::KIND_W-1:0]   access_kind_i,
  input  wire logic [ppmmu_pkg::ADDR_W-1:0]   address_i,
  input  wire logic [ppmmu_pkg::PAGE_W-1:0]   page_i,
  input  wire logic [ppmmu_pkg::FRAME_W-1:0]  frame_i,
  input  wire logic [ppmmu_pkg::RIGHTS_W-1:0] rights_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [ppmmu_pkg::PA_W-1:0]          physical_address_o,
  output logic [ppmmu_pkg::STATUS_W-1:0]      status_o,
  output logic                                tlb_hit_o
);
  import ppmmu_pkg::*;

  localparam int PRW        = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int PGW        = $clog2(LOGICAL_PAGES);
  localparam int PT_DEPTH   = PROCESSES * LOGICAL_PAGES;
  localparam int PTAW       = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
  localparam int OFFW       = $clog2(PAGE_BYTES);
  localparam int LPW        = ADDR_W - OFFW + 1;
  localparam int DATA_PAGES = DATA_BASE_BYTES / PAGE_BYTES;

  // request stage
  logic                in_fire;
  logic                exec_fire;
  logic                out_free;
  logic                busy_q;
  func_e               func_q;
  logic [PRW-1:0]      proc_q;
  logic                proc_ok_q;
  logic [PGW-1:0]      pg_q;
  logic                pg_ok_q;
  logic [PTAW-1:0]     pt_addr_q;
  logic [OFFW-1:0]     offset_q;
  logic [RIGHTS_W-1:0] need_q;
  logic [FRAME_W-1:0]  frame_q;
  logic [RIGHTS_W-1:0] rights_q;
  logic                frame_ok_q;

  logic [PRW-1:0]      proc_d;
  logic                proc_ok_d;
  logic [LPW-1:0]      lp;
  logic [PGW-1:0]      pg_d;
  logic                pg_ok_d;
  logic [PTAW-1:0]     pt_addr_d;
  logic [RIGHTS_W-1:0] need_d;

  // page table
  pt_entry_t           pt_mem [PT_DEPTH];
  pt_entry_t           pt_rd_q;
  logic [LOGICAL_PAGES-1:0] pt_valid_q [PROCESSES];
  logic                pt_we;
  logic                pt_clr;

  // tlb
  tlb_cmd_t            tlb_cmd;
  tlb_entry_t          fill_entry;
  tlb_res_t            tlb_res;

  // result
  status_e             res_status;
  logic                res_hit;
  logic [PA_W-1:0]     res_pa;
  logic                out_valid_q;
  logic [PA_W-1:0]     pa_q;
  status_e             status_q;
  logic                hit_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q;
  assign in_fire    = in_valid_i && !busy_q;
  assign exec_fire  = busy_q && out_free;

  // request decode
  always_comb begin
    proc_ok_d = (32'(process_i) < PROCESSES);
    proc_d    = proc_ok_d ? PRW'(process_i) : '0;
    lp        = LPW'(address_i >> OFFW);
    if (access_kind_i != ACC_EXEC) begin
      lp = lp + LPW'(DATA_PAGES);
    end
    if (func_i == FN_TRANSLATE) begin
      pg_ok_d = (32'(lp) < LOGICAL_PAGES);
      pg_d    = pg_ok_d ? PGW'(lp) : '0;
    end else begin
      pg_ok_d = (32'(page_i) < LOGICAL_PAGES);
      pg_d    = pg_ok_d ? PGW'(page_i) : '0;
    end
    pt_addr_d = PTAW'(int'(proc_d) * LOGICAL_PAGES + int'(pg_d));
    case (access_kind_i)
      ACC_EXEC:  need_d = RIGHT_EXEC;
      ACC_WRITE: need_d = RIGHT_WRITE;
      default:   need_d = RIGHT_READ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q     <= func_e'(func_i);
      proc_q     <= proc_d;
      proc_ok_q  <= proc_ok_d;
      pg_q       <= pg_d;
      pg_ok_q    <= pg_ok_d;
      pt_addr_q  <= pt_addr_d;
      offset_q   <= address_i[OFFW-1:0];
      need_q     <= need_d;
      frame_q    <= frame_i;
      rights_q   <= rights_i;
      frame_ok_q <= (32'(frame_i) < FRAMES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
    end else if (exec_fire) begin
      busy_q <= 1'b0;
    end
  end

  // page-table memory
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pt_rd_q <= pt_mem[pt_addr_d];
    end
    if (pt_we) begin
      pt_mem[pt_addr_q] <= '{frame: frame_q, rights: rights_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PROCESSES; i++) begin
        pt_valid_q[i] <= '0;
      end
    end else if (pt_clr) begin
      pt_valid_q[proc_q] <= '0;
    end else if (pt_we) begin
      pt_valid_q[proc_q][pg_q] <= (rights_q != '0);
    end
  end

  ppmmu_tlb #(
    .PROCESSES (PROCESSES),
    .TLB_DEPTH (TLB_DEPTH),
    .PRW       (PRW)
  ) u_tlb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tlb_cmd),
    .rd_proc_i (proc_d),
    .proc_i    (proc_q),
    .page_i    (PAGE_W'(pg_q)),
    .page_ok_i (pg_ok_q),
    .fill_i    (fill_entry),
    .res_o     (tlb_res)
  );

  assign fill_entry = '{page: PAGE_W'(pg_q), frame: pt_rd_q.frame, rights: pt_rd_q.rights};

  // execute stage
  always_comb begin
    tlb_cmd          = '0;
    tlb_cmd.rd_en    = in_fire;
    pt_we            = 1'b0;
    pt_clr           = 1'b0;
    res_status       = ST_OK;
    res_hit          = 1'b0;
    res_pa           = '0;
    case (func_q)
      FN_TRANSLATE: begin
        if (!proc_ok_q) begin
          res_status = ST_PAGE_FAULT;
        end else if (tlb_res.hit) begin
          res_hit = 1'b1;
          if ((tlb_res.rights & need_q) == '0) begin
            res_status = ST_PROT_FAULT;
          end else begin
            res_pa = PA_W'({tlb_res.frame, offset_q});
          end
        end else if (!pg_ok_q || !pt_valid_q[proc_q][pg_q]) begin
          res_status = ST_PAGE_FAULT;
        end else if ((pt_rd_q.rights & need_q) == '0) begin
          res_status = ST_PROT_FAULT;
        end else begin
          tlb_cmd.fill_en = exec_fire;
          res_pa          = PA_W'({pt_rd_q.frame, offset_q});
        end
      end
      FN_WRITE: begin
        if (!proc_ok_q || !pg_ok_q || ((rights_q != '0) && !frame_ok_q)) begin
          res_status = ST_IGNORED;
        end else begin
          pt_we = exec_fire;
        end
      end
      FN_FLUSH: begin
        if (!proc_ok_q) begin
          res_status = ST_IGNORED;
        end else begin
          tlb_cmd.flush_en = exec_fire;
        end
      end
      FN_CLEAR: begin
        if (!proc_ok_q) begin
          res_status = ST_IGNORED;
        end else begin
          tlb_cmd.flush_en = exec_fire;
          pt_clr           = exec_fire;
        end
      end
      default: begin
        res_status = ST_IGNORED;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      pa_q     <= res_pa;
      status_q <= res_status;
      hit_q    <= res_hit;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = pa_q;
  assign status_o           = status_q;
  assign tlb_hit_o          = hit_q;

  `ASSERT_PROP(a_accept_busy, clk_i, rst_ni, in_fire |=> busy_q, "accepted item not held")
  `ASSERT_PROP(a_exec_result, clk_i, rst_ni, exec_fire |=> out_valid_q, "result not loaded")
  `ASSERT_NEVER(a_fault_zero_pa, clk_i, rst_ni, out_valid_q && (status_q != ST_OK) && (pa_q != '0), "faulted item with address")
  `ASSERT_NEVER(a_hit_ignored, clk_i, rst_ni, out_valid_q && hit_q && (status_q == ST_IGNORED), "tlb hit on ignored item")

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// self-checking testbench of the per-process mmu with its own translation predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ppmmu_pkg::*;

  localparam int PROCESSES     = 4;
  localparam int TLB_DEPTH     = 4;
  localparam int LOGICAL_PAGES = 10;
  localparam int PAGE_BYTES    = 512;
  localparam int FRAMES        = 64;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 6;

  typedef struct packed {
    logic [PA_W-1:0] pa;
    status_e         status;
    logic            hit;
  } mmu_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i        = '0;
  logic [PROC_W-1:0]   process_i     = '0;
  logic [KIND_W-1:0]   access_kind_i = '0;
  logic [ADDR_W-1:0]   address_i     = '0;
  logic [PAGE_W-1:0]   page_i        = '0;
  logic [FRAME_W-1:0]  frame_i       = '0;
  logic [RIGHTS_W-1:0] rights_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [PA_W-1:0]     physical_address_o;
  logic [STATUS_W-1:0] status_o;
  logic                tlb_hit_o;

  per_process_tlb_mmu_top #(
    .PROCESSES    (PROCESSES),
    .TLB_DEPTH    (TLB_DEPTH),
    .LOGICAL_PAGES(LOGICAL_PAGES),
    .PAGE_BYTES   (PAGE_BYTES),
    .FRAMES       (FRAMES)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .process_i         (process_i),
    .access_kind_i     (access_kind_i),
    .address_i         (address_i),
    .page_i            (page_i),
    .frame_i           (frame_i),
    .rights_i          (rights_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .physical_address_o(physical_address_o),
    .status_o          (status_o),
    .tlb_hit_o         (tlb_hit_o)
  );

  // predictor state
  logic                map_valid  [PROCESSES][LOGICAL_PAGES];
  logic [FRAME_W-1:0]  map_frame  [PROCESSES][LOGICAL_PAGES];
  logic [RIGHTS_W-1:0] map_rights [PROCESSES][LOGICAL_PAGES];
  logic                tlb_valid  [PROCESSES][TLB_DEPTH];
  int unsigned         tlb_page   [PROCESSES][TLB_DEPTH];
  logic [FRAME_W-1:0]  tlb_frame  [PROCESSES][TLB_DEPTH];
  logic [RIGHTS_W-1:0] tlb_rights [PROCESSES][TLB_DEPTH];
  int unsigned         fill_slot  [PROCESSES];

  mmu_result_t expected_results[$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int translations    = 0;
  int hits_seen       = 0;
  int faults_seen     = 0;
  int mismatch_count  = 0;
  int quiet_cycles    = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void flush_tlb_row(int unsigned p);
    for (int i = 0; i < TLB_DEPTH; i++) tlb_valid[p][i] = 1'b0;
    fill_slot[p] = 0;
  endfunction

  function automatic mmu_result_t predict_mmu(func_e fn, logic [PROC_W-1:0] proc,
                                              logic [KIND_W-1:0] kind,
                                              logic [ADDR_W-1:0] addr,
                                              logic [PAGE_W-1:0] page,
                                              logic [FRAME_W-1:0] frame,
                                              logic [RIGHTS_W-1:0] rights);
    mmu_result_t         res;
    int unsigned         p;
    int unsigned         lp;
    int unsigned         slot;
    logic [RIGHTS_W-1:0] need;
    logic                found;
    res   = '{pa: '0, status: ST_OK, hit: 1'b0};
    p     = 32'(proc);
    found = 1'b0;
    if (p >= PROCESSES) begin
      res.status = (fn == FN_TRANSLATE) ? ST_PAGE_FAULT : ST_IGNORED;
    end else begin
      case (fn)
        FN_TRANSLATE: begin
          lp = addr / PAGE_BYTES;
          if (kind != ACC_EXEC) lp += DATA_BASE_BYTES / PAGE_BYTES;
          need = (kind == ACC_EXEC) ? RIGHT_EXEC : (kind == ACC_WRITE) ? RIGHT_WRITE :
                 RIGHT_READ;
          for (int i = 0; i < TLB_DEPTH; i++) begin
            if (!found && tlb_valid[p][i] && tlb_page[p][i] == lp) begin
              found   = 1'b1;
              res.hit = 1'b1;
              if ((tlb_rights[p][i] & need) == '0) res.status = ST_PROT_FAULT;
              else res.pa = PA_W'(tlb_frame[p][i] * PAGE_BYTES + addr % PAGE_BYTES);
            end
          end
          if (!found) begin
            if (lp >= LOGICAL_PAGES || !map_valid[p][lp]) begin
              res.status = ST_PAGE_FAULT;
            end else if ((map_rights[p][lp] & need) == '0) begin
              res.status = ST_PROT_FAULT;
            end else begin
              slot                = fill_slot[p] % TLB_DEPTH;
              tlb_valid[p][slot]  = 1'b1;
              tlb_page[p][slot]   = lp;
              tlb_frame[p][slot]  = map_frame[p][lp];
              tlb_rights[p][slot] = map_rights[p][lp];
              fill_slot[p]        = (slot + 1) % TLB_DEPTH;
              res.pa = PA_W'(map_frame[p][lp] * PAGE_BYTES + addr % PAGE_BYTES);
            end
          end
        end
        FN_WRITE: begin
          if (page >= LOGICAL_PAGES || (rights != '0 && frame >= FRAMES)) begin
            res.status = ST_IGNORED;
          end else begin
            map_valid[p][page]  = (rights != '0);
            map_frame[p][page]  = (rights != '0) ? frame : '0;
            map_rights[p][page] = rights;
          end
        end
        FN_FLUSH: flush_tlb_row(p);
        default: begin
          for (int i = 0; i < LOGICAL_PAGES; i++) begin
            map_valid[p][i]  = 1'b0;
            map_frame[p][i]  = '0;
            map_rights[p][i] = '0;
          end
          flush_tlb_row(p);
        end
      endcase
    end
    if (res.status != ST_OK) res.pa = '0;
    return res;
  endfunction

  task automatic send_item(input func_e fn, input logic [PROC_W-1:0] proc,
                           input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                           input logic [PAGE_W-1:0] page, input logic [FRAME_W-1:0] frame,
                           input logic [RIGHTS_W-1:0] rights);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    process_i     <= proc;
    access_kind_i <= kind;
    address_i     <= addr;
    page_i        <= page;
    frame_i       <= frame;
    rights_i      <= rights;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_mmu(fn, proc, kind, addr, page, frame, rights));
    items_sent++;
  endtask

  task automatic map_page(input logic [PROC_W-1:0] proc, input logic [PAGE_W-1:0] page,
                          input logic [FRAME_W-1:0] frame, input logic [RIGHTS_W-1:0] rights);
    send_item(FN_WRITE, proc, KIND_W'($urandom_range(3)), ADDR_W'($urandom_range(8191)),
              page, frame, rights);
  endtask

  task automatic translate(input logic [PROC_W-1:0] proc, input logic [KIND_W-1:0] kind,
                           input logic [ADDR_W-1:0] addr);
    send_item(FN_TRANSLATE, proc, kind, addr, PAGE_W'($urandom_range(15)),
              FRAME_W'($urandom_range(63)), RIGHTS_W'($urandom_range(7)));
  endtask

  task automatic table_cmd(input func_e fn, input logic [PROC_W-1:0] proc);
    send_item(fn, proc, KIND_W'($urandom_range(3)), ADDR_W'($urandom_range(8191)),
              PAGE_W'($urandom_range(15)), FRAME_W'($urandom_range(63)),
              RIGHTS_W'($urandom_range(7)));
  endtask

  task automatic test_empty_table;
    translate(2'd0, ACC_EXEC, 13'd0);
    translate(2'd3, ACC_READ, 13'd8191);
    translate(2'd1, 2'd3, 13'd0);
    map_page(2'd2, 4'd15, 6'd63, 3'd7);
  endtask

  task automatic test_map_and_translate;
    map_page(2'd0, 4'd0, 6'd63, RIGHT_EXEC);
    map_page(2'd0, 4'd2, 6'd0, RIGHT_READ);
    map_page(2'd0, 4'd3, 6'd5, 3'd7);
    translate(2'd0, ACC_EXEC, 13'd511);
    translate(2'd0, ACC_EXEC, 13'd0);
    translate(2'd0, ACC_READ, 13'd0);
    translate(2'd0, ACC_WRITE, 13'd5);
    translate(2'd0, 2'd3, 13'd100);
    translate(2'd0, ACC_WRITE, 13'd1023);
    translate(2'd0, ACC_EXEC, 13'd1024);
    map_page(2'd0, 4'd10, 6'd1, 3'd7);
    map_page(2'd0, 4'd3, 6'd0, 3'd0);
    translate(2'd0, ACC_WRITE, 13'd1023);
  endtask

  task automatic test_tlb_replacement;
    map_page(2'd0, 4'd1, 6'd1, 3'd7);
    translate(2'd0, ACC_EXEC, 13'd512);
    translate(2'd0, ACC_EXEC, 13'd0);
    translate(2'd0, ACC_READ, 13'd0);
    table_cmd(FN_FLUSH, 2'd0);
    translate(2'd0, ACC_READ, 13'd1023);
    table_cmd(FN_CLEAR, 2'd0);
    translate(2'd0, ACC_EXEC, 13'd512);
  endtask

  // mostly translations of in-range pages, with writes, flushes, clears and stray addresses
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    int                  sel;
    logic [PROC_W-1:0]   proc;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   addr;
    logic [PAGE_W-1:0]   page;
    logic [RIGHTS_W-1:0] rights;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      sel    = $urandom_range(99);
      proc   = PROC_W'($urandom_range(PROCESSES - 1));
      kind   = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      addr   = ADDR_W'($urandom_range(8191));
      page   = PAGE_W'($urandom_range(15));
      rights = RIGHTS_W'($urandom_range(7));
      if (sel < 62) begin
        if ($urandom_range(9) != 0) begin
          addr = (kind == ACC_EXEC) ? ADDR_W'($urandom_range(LOGICAL_PAGES * PAGE_BYTES - 1)) :
                 ADDR_W'($urandom_range(LOGICAL_PAGES * PAGE_BYTES - DATA_BASE_BYTES - 1));
        end
        send_item(FN_TRANSLATE, proc, kind, addr, page, FRAME_W'($urandom_range(63)), rights);
      end else if (sel < 90) begin
        if ($urandom_range(9) != 0) page = PAGE_W'($urandom_range(LOGICAL_PAGES - 1));
        if ($urandom_range(7) != 0) rights = RIGHTS_W'($urandom_range(1, 7));
        else rights = '0;
        send_item(FN_WRITE, proc, kind, addr, page, FRAME_W'($urandom_range(63)), rights);
      end else begin
        send_item((sel < 97) ? FN_FLUSH : FN_CLEAR, proc, kind, addr, page,
                  FRAME_W'($urandom_range(63)), rights);
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    mmu_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result pa=%0d status=%0d hit=%0d", $time,
                 physical_address_o, status_o, tlb_hit_o);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (physical_address_o !== exp_res.pa) begin
          $display("%0t: physical address mismatch, expected %0d, actual %0d", $time,
                   exp_res.pa, physical_address_o);
          mismatch_count++;
        end
        if (status_o !== exp_res.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   exp_res.status, status_o);
          mismatch_count++;
        end
        if (tlb_hit_o !== exp_res.hit) begin
          $display("%0t: tlb hit mismatch, expected %0d, actual %0d", $time,
                   exp_res.hit, tlb_hit_o);
          mismatch_count++;
        end
        results_checked++;
        if (exp_res.hit) hits_seen++;
        if (exp_res.status == ST_PAGE_FAULT || exp_res.status == ST_PROT_FAULT) faults_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o && func_i == FN_TRANSLATE) translations <= translations + 1;
  end

  initial begin
    for (int p = 0; p < PROCESSES; p++) begin
      for (int i = 0; i < LOGICAL_PAGES; i++) begin
        map_valid[p][i]  = 1'b0;
        map_frame[p][i]  = '0;
        map_rights[p][i] = '0;
      end
      for (int i = 0; i < TLB_DEPTH; i++) begin
        tlb_valid[p][i]  = 1'b0;
        tlb_page[p][i]   = 0;
        tlb_frame[p][i]  = '0;
        tlb_rights[p][i] = '0;
      end
      fill_slot[p] = 0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table;
    test_map_and_translate;
    test_tlb_replacement;
    test_random_traffic(400, 0, 0);
    test_random_traffic(400, 63, 0);
    test_random_traffic(400, 0, 63);
    test_random_traffic(400, 33, 33);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests, %0d of them translations: %0d tlb hits, %0d faults",
             items_sent, translations, hits_seen, faults_seen);
    $display("checked %0d results under four sender and receiver idling mixes, %0d mismatches",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
